// ===== hw/rtl/range_window_cache_fifo_macros.svh =====
// Assertion macros for the range window cache.
`ifndef RANGE_WINDOW_CACHE_FIFO_MACROS_SVH
`define RANGE_WINDOW_CACHE_FIFO_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RWC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rwc: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RWC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rwc: next-cycle check failed");

`endif

// ===== hw/rtl/rwc_pkg.sv =====
// Types, constants and codes shared by the range window cache modules.
package rwc_pkg;

   localparam int ENTRIES    = 5;
   localparam int ALIGN_BITS = 16;

   localparam int ADDR_W  = 48;
   localparam int LEN_W   = 32;
   localparam int SLOT_W  = 3;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ALU_W   = ADDR_W + 1;
   localparam int CSR_IDX_W = 1;

   localparam logic [ADDR_W-1:0] ALIGN_MASK =
      ADDR_W'((64'd1 << ALIGN_BITS) - 64'd1);
   localparam logic [LEN_W-1:0]  WINDOW_SIZE_RESET = 32'd6553600;
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ENTRIES - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_FILE_SIZE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] start_req;
      logic [LEN_W-1:0]  length;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [LEN_W-1:0]  offset;
      logic [ADDR_W-1:0] window_start;
      logic [LEN_W-1:0]  window_length;
      logic              status;
   } rsp_type;

   typedef enum logic [0:0] {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_LO,
      ST_HI,
      ST_LEN,
      ST_CHK,
      ST_CLIP,
      ST_END
   } state_type;

   // table write request
   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] stop;
   } tbl_wr_type;

   // table read data at the scan index
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] stop;
   } tbl_rd_type;

endpackage

// ===== hw/rtl/range_window_cache_fifo.sv =====
// Top level of the range window cache: config registers, result register, checks.
//
// A request (start_req, length) is taken when start is high and busy is low;
// busy then stays high until the result is out. One 49-bit add/subtract unit
// does every sum and compare, so the entries are scanned one at a time after
// the range end is summed; a hit answers at the first matching entry, a miss
// goes on to check, clip and install a window. The next request can be taken
// again once busy is low. Each result appears on rsp_data for exactly one
// cycle with rsp_valid high and must be captured then; there is no
// backpressure. On a miss the window is aligned down to 2^ALIGN_BITS bytes,
// clipped at file_size and installed in round-robin order; status = 1 means
// the aligned start lies past the file end and nothing was installed.
// csr_index 0 writes file_size, 1 writes window_size; write only while idle.
`include "range_window_cache_fifo_macros.svh"

module range_window_cache_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  rwc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output rwc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [rwc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rwc_pkg::ADDR_W-1:0]        csr_wdata
);

   logic [rwc_pkg::ADDR_W-1:0] file_size_ff;
   logic [rwc_pkg::LEN_W-1:0]  window_size_ff;
   logic                       rsp_valid_ff;
   rwc_pkg::rsp_type           rsp_data_ff;

   logic                       accept;
   logic                       seq_done;
   rwc_pkg::rsp_type           seq_rsp;
   rwc_pkg::tbl_wr_type        tbl_wr;
   rwc_pkg::tbl_rd_type        tbl_rd;
   logic [rwc_pkg::IDX_W-1:0]  tbl_idx;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff   <= '0;
         window_size_ff <= rwc_pkg::WINDOW_SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rwc_pkg::CSR_FILE_SIZE:   file_size_ff   <= csr_wdata;
            rwc_pkg::CSR_WINDOW_SIZE: window_size_ff <= csr_wdata[rwc_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= seq_done;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_done) begin
         rsp_data_ff <= seq_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   rwc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .file_size   (file_size_ff),
      .window_size (window_size_ff),
      .busy        (busy),
      .done        (seq_done),
      .rsp         (seq_rsp),
      .tbl_wr      (tbl_wr),
      .tbl_idx     (tbl_idx),
      .tbl_rd      (tbl_rd)
   );

   rwc_table u_table (
      .clock  (clock),
      .reset  (reset),
      .wr     (tbl_wr),
      .rd_idx (tbl_idx),
      .rd     (tbl_rd)
   );

   // an accepted request always occupies the sequencer
   `RWC_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy)
   // results are single-cycle strobes, never back to back
   `RWC_ASSERT_NXT(a_rsp_strobe, clock, reset, rsp_valid, !rsp_valid)
   // the sequencer is back to idle when its result shows
   `RWC_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // a flagged request is never reported as a hit
   `RWC_ASSERT_IMP(a_status_nohit, clock, reset, rsp_valid && rsp_data.status,
      !rsp_data.hit)

endmodule

// ===== hw/rtl/rwc_alu.sv =====
// Shared 49-bit add/subtract unit used for every sum and compare.
module rwc_alu (
   input  rwc_pkg::alu_op_type          op,
   input  logic [rwc_pkg::ALU_W-1:0]    a,
   input  logic [rwc_pkg::ALU_W-1:0]    b,
   output logic [rwc_pkg::ALU_W-1:0]    res,
   output logic                         borrow
);

   logic [rwc_pkg::ALU_W:0] full;

   always_comb begin
      unique case (op)
         rwc_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
         rwc_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
         default:          full = '0;
      endcase
   end

   // top bit is carry on add, borrow (a < b) on subtract
   assign res    = full[rwc_pkg::ALU_W-1:0];
   assign borrow = full[rwc_pkg::ALU_W];

endmodule

// ===== hw/rtl/rwc_table.sv =====
// Window entry storage with per-entry valid bits, one write and one read port.
module rwc_table (
   input  logic                          clock,
   input  logic                          reset,
   input  rwc_pkg::tbl_wr_type           wr,
   input  logic [rwc_pkg::IDX_W-1:0]     rd_idx,
   output rwc_pkg::tbl_rd_type           rd
);

   logic [rwc_pkg::ADDR_W-1:0]  start_ff [rwc_pkg::ENTRIES];
   logic [rwc_pkg::ADDR_W-1:0]  stop_ff  [rwc_pkg::ENTRIES];
   logic [rwc_pkg::ENTRIES-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.we) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we) begin
         start_ff[wr.idx] <= wr.start;
         stop_ff[wr.idx]  <= wr.stop;
      end
   end

   assign rd.valid = valid_ff[rd_idx];
   assign rd.start = start_ff[rd_idx];
   assign rd.stop  = stop_ff[rd_idx];

endmodule

// ===== hw/rtl/rwc_seq.sv =====
// Sequencer: scans entries one compare at a time; on a miss aligns, clips and installs.
module rwc_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  rwc_pkg::req_type              req,
   input  logic [rwc_pkg::ADDR_W-1:0]    file_size,
   input  logic [rwc_pkg::LEN_W-1:0]     window_size,
   output logic                          busy,
   output logic                          done,
   output rwc_pkg::rsp_type              rsp,
   output rwc_pkg::tbl_wr_type           tbl_wr,
   output logic [rwc_pkg::IDX_W-1:0]     tbl_idx,
   input  rwc_pkg::tbl_rd_type           tbl_rd
);

   rwc_pkg::state_type state_ff, state_in;
   logic [rwc_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [rwc_pkg::IDX_W-1:0]  slot_ff, slot_in;
   logic [rwc_pkg::ADDR_W-1:0] start_ff, start_in;
   logic [rwc_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [rwc_pkg::ALU_W-1:0]  stop_ff, stop_in;
   logic [rwc_pkg::LEN_W-1:0]  offset_ff, offset_in;
   logic [rwc_pkg::ADDR_W-1:0] rem_ff, rem_in;
   logic [rwc_pkg::ADDR_W-1:0] wlen_ff, wlen_in;

   rwc_pkg::alu_op_type        alu_op;
   logic [rwc_pkg::ALU_W-1:0]  alu_a, alu_b, alu_res;
   logic                       alu_borrow;
   logic [rwc_pkg::ADDR_W-1:0] aligned;
   logic [rwc_pkg::IDX_W-1:0]  idx_next;
   logic [rwc_pkg::IDX_W-1:0]  slot_next;

   rwc_alu u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .res    (alu_res),
      .borrow (alu_borrow)
   );

   assign aligned   = start_ff & ~rwc_pkg::ALIGN_MASK;
   assign idx_next  = idx_ff + 1'b1;
   assign slot_next = (slot_ff == rwc_pkg::LAST_IDX) ? '0 : slot_ff + 1'b1;
   assign tbl_idx   = idx_ff;
   assign busy      = (state_ff != rwc_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rwc_pkg::ST_IDLE;
         idx_ff   <= '0;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      len_ff    <= len_in;
      stop_ff   <= stop_in;
      offset_ff <= offset_in;
      rem_ff    <= rem_in;
      wlen_ff   <= wlen_in;
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      slot_in   = slot_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      stop_in   = stop_ff;
      offset_in = offset_ff;
      rem_in    = rem_ff;
      wlen_in   = wlen_ff;
      alu_op    = rwc_pkg::ALU_SUB;
      alu_a     = '0;
      alu_b     = '0;
      done      = 1'b0;
      rsp       = '0;
      tbl_wr    = '0;

      unique case (state_ff)
         rwc_pkg::ST_IDLE: begin
            if (accept) begin
               start_in = req.start_req;
               len_in   = req.length;
               idx_in   = '0;
               state_in = rwc_pkg::ST_SUM;
            end
         end

         rwc_pkg::ST_SUM: begin
            alu_op   = rwc_pkg::ALU_ADD;
            alu_a    = {1'b0, start_ff};
            alu_b    = rwc_pkg::ALU_W'(len_ff);
            stop_in  = alu_res;
            state_in = rwc_pkg::ST_LO;
         end

         // entry_start <= start ?
         rwc_pkg::ST_LO: begin
            alu_a = {1'b0, start_ff};
            alu_b = {1'b0, tbl_rd.start};
            if (tbl_rd.valid && !alu_borrow) begin
               offset_in = alu_res[rwc_pkg::LEN_W-1:0];
               state_in  = rwc_pkg::ST_HI;
            end else if (idx_ff == rwc_pkg::LAST_IDX) begin
               state_in = rwc_pkg::ST_CHK;
            end else begin
               idx_in = idx_next;
            end
         end

         // stop <= entry_end ?
         rwc_pkg::ST_HI: begin
            alu_a = {1'b0, tbl_rd.stop};
            alu_b = stop_ff;
            if (!alu_borrow) begin
               state_in = rwc_pkg::ST_LEN;
            end else if (idx_ff == rwc_pkg::LAST_IDX) begin
               state_in = rwc_pkg::ST_CHK;
            end else begin
               idx_in   = idx_next;
               state_in = rwc_pkg::ST_LO;
            end
         end

         rwc_pkg::ST_LEN: begin
            alu_a             = {1'b0, tbl_rd.stop};
            alu_b             = {1'b0, tbl_rd.start};
            done              = 1'b1;
            rsp.hit           = 1'b1;
            rsp.slot          = rwc_pkg::SLOT_W'(idx_ff);
            rsp.offset        = offset_ff;
            rsp.window_start  = tbl_rd.start;
            rsp.window_length = alu_res[rwc_pkg::LEN_W-1:0];
            state_in          = rwc_pkg::ST_IDLE;
         end

         // miss: remaining file bytes past the aligned start
         rwc_pkg::ST_CHK: begin
            alu_a = {1'b0, file_size};
            alu_b = {1'b0, aligned};
            if (alu_borrow) begin
               done       = 1'b1;
               rsp.status = 1'b1;
               state_in   = rwc_pkg::ST_IDLE;
            end else begin
               rem_in   = alu_res[rwc_pkg::ADDR_W-1:0];
               state_in = rwc_pkg::ST_CLIP;
            end
         end

         // aligned + window_size >= file_size  <=>  window_size >= rem
         rwc_pkg::ST_CLIP: begin
            alu_a = rwc_pkg::ALU_W'(window_size);
            alu_b = {1'b0, rem_ff};
            if (!alu_borrow) begin
               wlen_in = rem_ff;
            end else begin
               wlen_in = rwc_pkg::ADDR_W'(window_size);
            end
            state_in = rwc_pkg::ST_END;
         end

         rwc_pkg::ST_END: begin
            alu_op            = rwc_pkg::ALU_ADD;
            alu_a             = {1'b0, aligned};
            alu_b             = {1'b0, wlen_ff};
            tbl_wr.we         = 1'b1;
            tbl_wr.idx        = slot_ff;
            tbl_wr.start      = aligned;
            tbl_wr.stop       = alu_res[rwc_pkg::ADDR_W-1:0];
            done              = 1'b1;
            rsp.slot          = rwc_pkg::SLOT_W'(slot_ff);
            rsp.offset        = rwc_pkg::LEN_W'(start_ff & rwc_pkg::ALIGN_MASK);
            rsp.window_start  = aligned;
            rsp.window_length = wlen_ff[rwc_pkg::LEN_W-1:0];
            slot_in           = slot_next;
            state_in          = rwc_pkg::ST_IDLE;
         end

         default: begin
            state_in = rwc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sim/range_window_cache_fifo_checker.sv =====
// Checker for the range window cache: predicts every result and compares it field by field.
`timescale 1ns / 1ps

module range_window_cache_fifo_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  rwc_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  rwc_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [rwc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rwc_pkg::ADDR_W-1:0]    csr_wdata,
   output int                            results_due,
   output int                            mismatches
);
   import rwc_pkg::*;

   logic [ADDR_W-1:0] win_lo [ENTRIES];
   logic [ADDR_W-1:0] win_hi [ENTRIES];
   logic              win_live [ENTRIES];
   int unsigned       fill_slot;
   logic [ADDR_W-1:0] file_bytes;
   logic [LEN_W-1:0]  window_bytes;
   rsp_type           due_rsps [$];
   int                bad_count = 0;

   // Looks the range up in the window table; a miss installs the new window.
   function automatic rsp_type serve_range(req_type rq);
      logic [ALU_W-1:0]  range_end;
      logic [ALU_W-1:0]  reach;
      logic [ADDR_W-1:0] aligned;
      logic [ADDR_W-1:0] span;
      logic              found;
      rsp_type           r;
      int                s;
      r = '0;
      found = 1'b0;
      range_end = {1'b0, rq.start_req} + ALU_W'(rq.length);
      for (int i = 0; i < ENTRIES; i++) begin
         if (!found && win_live[i] && win_lo[i] <= rq.start_req &&
             range_end <= {1'b0, win_hi[i]}) begin
            found = 1'b1;
            r.hit = 1'b1;
            r.slot = SLOT_W'(i);
            r.offset = LEN_W'(rq.start_req - win_lo[i]);
            r.window_start = win_lo[i];
            r.window_length = LEN_W'(win_hi[i] - win_lo[i]);
         end
      end
      if (!found) begin
         aligned = rq.start_req & ~ALIGN_MASK;
         if (aligned > file_bytes) begin
            r.status = 1'b1;
         end else begin
            // clip at the file end, compared at full width
            reach = {1'b0, aligned} + ALU_W'(window_bytes);
            span = (reach >= {1'b0, file_bytes}) ? file_bytes - aligned
                                                 : ADDR_W'(window_bytes);
            s = (fill_slot >= ENTRIES) ? 0 : int'(fill_slot);
            win_lo[s] = aligned;
            win_hi[s] = aligned + span;
            win_live[s] = 1'b1;
            fill_slot = (s + 1) % ENTRIES;
            r.slot = SLOT_W'(s);
            r.offset = LEN_W'(rq.start_req - aligned);
            r.window_start = aligned;
            r.window_length = LEN_W'(span);
         end
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: rsp %s mismatch, expected %h, got %h", $time, name, want, got);
         bad_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            win_lo[i] = '0;
            win_hi[i] = '0;
            win_live[i] = 1'b0;
         end
         fill_slot = 0;
         file_bytes = '0;
         window_bytes = WINDOW_SIZE_RESET;
         due_rsps.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_FILE_SIZE) begin
               file_bytes = csr_wdata;
            end else if (csr_index == CSR_WINDOW_SIZE) begin
               window_bytes = csr_wdata[LEN_W-1:0];
            end
         end
         // accept first: a result at this edge always belongs to an older item
         if (start && !busy) begin
            due_rsps.push_back(serve_range(req_data));
         end
         if (rsp_valid) begin
            if (due_rsps.size() == 0) begin
               $display("%0t: unexpected rsp, expected none, got %h", $time, rsp_data);
               bad_count++;
            end else begin
               want = due_rsps.pop_front();
               check_field("hit", 64'(want.hit), 64'(rsp_data.hit));
               check_field("slot", 64'(want.slot), 64'(rsp_data.slot));
               check_field("offset", 64'(want.offset), 64'(rsp_data.offset));
               check_field("window_start", 64'(want.window_start),
                           64'(rsp_data.window_start));
               check_field("window_length", 64'(want.window_length),
                           64'(rsp_data.window_length));
               check_field("status", 64'(want.status), 64'(rsp_data.status));
            end
         end
      end
      results_due <= due_rsps.size();
      mismatches <= bad_count;
   end

endmodule

// ===== sim/range_window_cache_fifo_test.sv =====
// Testbench top for the range window cache: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module range_window_cache_fifo_test;
   import rwc_pkg::*;

   localparam logic [ADDR_W-1:0] ADDR_MAX    = '1;
   localparam logic [LEN_W-1:0]  LEN_MAX     = '1;
   localparam int                CYCLE_LIMIT = 300000;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FILE_SIZE;
   logic [ADDR_W-1:0]    csr_wdata = '0;
   int                   results_due;
   int                   mismatches;

   // current settings, kept for shaping addresses
   logic [ADDR_W-1:0]    file_now = '0;
   logic [LEN_W-1:0]     window_now = WINDOW_SIZE_RESET;

   range_window_cache_fifo i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   range_window_cache_fifo_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .results_due (results_due),
      .mismatches  (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      rand64 = {$urandom(), $urandom()};
   endfunction

   // holds start high until the item is taken
   task automatic issue_request(input logic [ADDR_W-1:0] addr,
                                input logic [LEN_W-1:0] count);
      req_type item;
      item.start_req = addr;
      item.length = count;
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   // stop sending and wait for every outstanding result
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (results_due != 0 || busy);
      repeat (20) @(posedge clock);
   endtask

   task automatic program_window(input logic [ADDR_W-1:0] fsize,
                                 input logic [LEN_W-1:0] wsize);
      csr_we <= 1'b1;
      csr_index <= CSR_FILE_SIZE;
      csr_wdata <= fsize;
      @(posedge clock);
      csr_index <= CSR_WINDOW_SIZE;
      csr_wdata <= ADDR_W'(wsize);
      @(posedge clock);
      csr_we <= 1'b0;
      file_now = fsize;
      window_now = wsize;
   endtask

   // Most items land on a few hot regions so the table actually hits;
   // the rest are scattered addresses and probes around the file end.
   task automatic random_phase(input int items, input bit with_gaps);
      logic [ADDR_W-1:0] bases [6];
      logic [63:0]       lim;
      logic [63:0]       span;
      logic [63:0]       dist_end;
      logic [63:0]       probe;
      logic [95:0]       junk;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      int                pick;
      int                kind;
      lim = 64'(file_now) + 64'h2_0000;
      if (lim > 64'(ADDR_MAX)) lim = 64'(ADDR_MAX);
      for (int k = 0; k < 6; k++) bases[k] = ADDR_W'(rand64() % (lim + 1));
      span = ((window_now < 32'h10_0000) ? 64'(window_now) : 64'h10_0000) + 1;
      for (int n = 0; n < items; n++) begin
         if (with_gaps && $urandom_range(99) < 35) begin
            junk = {$urandom(), $urandom(), $urandom()};
            start <= 1'b0;
            req_data <= junk[$bits(req_type)-1:0];
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         kind = $urandom_range(99);
         if (kind < 70) begin
            pick = $urandom_range(5);
            if ($urandom_range(19) == 0) bases[pick] = ADDR_W'(rand64() % (lim + 1));
            addr = ADDR_W'(64'(bases[pick] & ~ALIGN_MASK) + rand64() % span);
            case ($urandom_range(3))
               0: len = '0;
               3: len = $urandom() >> $urandom_range(31);
               default: len = LEN_W'(rand64() % span);
            endcase
         end else if (kind < 85) begin
            addr = ADDR_W'(rand64());
            len = $urandom() >> $urandom_range(31);
         end else begin
            dist_end = 64'($urandom_range(32'h2_0000));
            if ($urandom_range(1) == 1) begin
               probe = 64'(file_now) + dist_end;
               addr = (probe > 64'(ADDR_MAX)) ? ADDR_MAX : ADDR_W'(probe);
            end else begin
               addr = (64'(file_now) >= dist_end) ? ADDR_W'(64'(file_now) - dist_end) : '0;
            end
            len = $urandom_range(32'h1000);
         end
         issue_request(addr, len);
      end
   endtask

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("range_window_cache_fifo test failed");
      $finish;
   end

   initial begin
      logic [ADDR_W-1:0] fsize;
      logic [LEN_W-1:0]  wsize;
      int                items;
      bit                gaps;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: empty file, so a zero-length window at 0
      issue_request(48'h0, 32'h0);
      issue_request(48'h0, 32'h0);
      issue_request(48'h1_0000, 32'h1);
      settle();

      program_window(48'h3_0000, 32'd100);
      issue_request(48'h1_0032, 32'd100);   // loaded window ends short of the range
      issue_request(48'h1_0032, 32'd50);    // hit ending exactly on the window end
      issue_request(48'h3_0000, 32'h0);     // aligned start equal to file end
      issue_request(48'h2_FFFF, 32'h5);
      issue_request(48'h3_FFFF, 32'h0);
      issue_request(48'h4_0000, 32'h7);     // past the file end
      settle();

      program_window(48'h2_8000, 32'h0);
      issue_request(48'h2_1000, 32'h3);     // zero window size, slot wraps to 0
      issue_request(48'h2_0000, 32'h0);
      settle();

      program_window(ADDR_MAX, LEN_MAX);
      issue_request(ADDR_MAX, LEN_MAX);
      issue_request(48'h0, LEN_MAX);
      issue_request(48'h0, LEN_MAX);
      issue_request(48'hFFFF_FFFF_0000, 32'hFFFF);
      issue_request(48'h1, LEN_MAX);
      settle();

      for (int ph = 0; ph < 8; ph++) begin
         gaps = 1'b1;
         case (ph)
            0: begin fsize = 48'h8_0000; wsize = 32'h1_8000; items = 100; end
            1: begin fsize = ADDR_MAX; wsize = LEN_MAX; items = 100; end
            2: begin
               fsize = ADDR_W'($urandom_range(32'hFF_FFFF));
               wsize = WINDOW_SIZE_RESET;
               items = 120;
               gaps = 1'b0;
            end
            3: begin
               fsize = 48'h5_0000 + ADDR_W'($urandom_range(32'hFFFF));
               wsize = '0;
               items = 80;
            end
            4: begin fsize = '0; wsize = $urandom(); items = 60; end
            5: begin fsize = ADDR_W'(rand64()); wsize = $urandom(); items = 120; end
            6: begin fsize = ADDR_W'($urandom_range(32'h3F_FFFF)); wsize = 32'h1; items = 100; end
            default: begin
               fsize = ADDR_W'($urandom_range(32'h3FFF_FFFF));
               wsize = $urandom_range(32'h100, 32'h4_0000);
               items = 120;
            end
         endcase
         program_window(fsize, wsize);
         random_phase(items, gaps);
         settle();
      end

      if (mismatches == 0) begin
         $display("range_window_cache_fifo test passed");
      end else begin
         $display("range_window_cache_fifo test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rwc_pkg.sv
hw/rtl/rwc_alu.sv
hw/rtl/rwc_table.sv
hw/rtl/rwc_seq.sv
hw/rtl/range_window_cache_fifo.sv
sim/range_window_cache_fifo_checker.sv
sim/range_window_cache_fifo_test.sv
